// ===== hdl/gpfi_pkg.sv =====
// ----------------------------------------------------------------------------
// gpfi_pkg
// Shared widths, codes and types of the grid plane fit interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package gpfi_pkg;

   // default storage size of the sample grid
   localparam int DEF_MAX_COLUMNS = 256;
   localparam int DEF_MAX_ROWS    = 256;

   // field widths
   localparam int SAMPLE_W  = 16;
   localparam int INDEX_W   = 8;
   localparam int OFFSET_W  = 16;
   localparam int SELECT_W  = 2;
   localparam int DIM_W     = 9;
   localparam int VALUE_W   = 27;
   localparam int SLOPE_W   = 26;

   // packed stream widths
   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_USER_W = 3;

   // request kinds
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // output select codes
   localparam logic [SELECT_W-1:0] SEL_VALUE  = 2'd0;
   localparam logic [SELECT_W-1:0] SEL_SLOPES = 2'd1;
   localparam logic [SELECT_W-1:0] SEL_BOTH   = 2'd2;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_GRID_WIDTH  = 1'b0,
      CSR_GRID_HEIGHT = 1'b1
   } csr_index_type;

   // position tag that follows a sample read out of the grid memory
   typedef struct packed {
      logic valid;
      logic at_lc;
      logic at_hc;
      logic at_lr;
      logic at_hr;
   } read_tag_type;

endpackage

`default_nettype wire

// ===== hdl/grid_plane_fit_interpolator.sv =====
// Write requests may follow back to back.
// A query reads its window through the one-sample-per-cycle grid memory
// read port and uses the shared multiplier for three divides and two products.
// A query outside the grid goes from setup straight to the response. Synchronous
// active-high reset clears control state and sets the grid size to 256; other
// data registers and grid contents are not cleared.
// ----------------------------------------------------------------------------
// grid_plane_fit_interpolator
// Sample grid with a least-squares plane fit over an up to 3x3 window and fixed-point evaluation.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_plane_fit_interpolator #(
   parameter int MAX_COLUMNS = gpfi_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = gpfi_pkg::DEF_MAX_ROWS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // column, row, sample_value, offset_col, offset_row, output_select, zero fill
   input  logic [gpfi_pkg::REQ_DATA_W-1:0]   req_tdata,
   // mode
   input  logic [gpfi_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // interp_value, slope_col, slope_row, zero fill
   output logic [gpfi_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // value_valid, slopes_valid, range_error
   output logic [gpfi_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  gpfi_pkg::csr_index_type           csr_index,
   input  logic [gpfi_pkg::DIM_W-1:0]        csr_data
);

   import gpfi_pkg::*;

   localparam int ADDR_W   = $clog2(MAX_ROWS * MAX_COLUMNS);
   localparam int DEPTH    = MAX_ROWS * MAX_COLUMNS;
   localparam int DIM_MAX  = (1 << DIM_W) - 1;
   localparam logic [DIM_W-1:0] COL_CAP =
      (MAX_COLUMNS > DIM_MAX) ? DIM_W'(DIM_MAX) : DIM_W'(MAX_COLUMNS);
   localparam logic [DIM_W-1:0] ROW_CAP =
      (MAX_ROWS > DIM_MAX) ? DIM_W'(DIM_MAX) : DIM_W'(MAX_ROWS);
   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

   // arithmetic widths
   localparam int ACC_W   = 20;                  // window sums
   localparam int FRAC_W  = 8;
   localparam int NUM_W   = ACC_W - 1 + FRAC_W + 1;  // 2*|sum|*256 + d
   localparam int RECIP_SH = 32;
   localparam int MUL_A_W = NUM_W + 1;
   localparam int MUL_B_W = 32;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int COEF_W  = SLOPE_W;
   localparam int VACC_W  = 45;
   localparam int VAL_SH  = 15;
   localparam logic [VACC_W-1:0] VAL_HALF = VACC_W'(1) << (VAL_SH - 1);

   // reciprocals of the odd divisor factors
   localparam logic [MUL_B_W-1:0] RECIP_3 = 32'd1431655765;
   localparam logic [MUL_B_W-1:0] RECIP_9 = 32'd477218588;

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b0000000001,
      ST_SETUP   = 10'b0000000010,
      ST_READ    = 10'b0000000100,
      ST_DRAIN   = 10'b0000001000,
      ST_DIV_MUL = 10'b0000010000,
      ST_DIV_FIX = 10'b0000100000,
      ST_MUL_X   = 10'b0001000000,
      ST_MUL_Y   = 10'b0010000000,
      ST_SUM     = 10'b0100000000,
      ST_DONE    = 10'b1000000000
   } state_type;

   typedef enum logic [1:0] {
      QTY_A = 2'd0,
      QTY_B = 2'd1,
      QTY_C = 2'd2
   } qty_type;

   typedef enum logic [1:0] {
      DIV_ONE   = 2'd0,
      DIV_THREE = 2'd1,
      DIV_NINE  = 2'd2
   } div_type;

   // request fields
   logic                        req_mode;
   logic [INDEX_W-1:0]          req_col;
   logic [INDEX_W-1:0]          req_row;
   logic signed [SAMPLE_W-1:0]  req_sample;
   logic signed [OFFSET_W-1:0]  req_x;
   logic signed [OFFSET_W-1:0]  req_y;
   logic [SELECT_W-1:0]         req_sel;
   logic                        req_accept;

   // registers and next values
   state_type                   state_ff, state_in;
   logic [INDEX_W-1:0]          col_ff, col_in;
   logic [INDEX_W-1:0]          row_ff, row_in;
   logic signed [OFFSET_W-1:0]  x_ff, x_in;
   logic signed [OFFSET_W-1:0]  y_ff, y_in;
   logic [SELECT_W-1:0]         sel_ff, sel_in;
   logic                        err_ff, err_in;
   logic [DIM_W-1:0]            lc_ff, lc_in, hc_ff, hc_in;
   logic [DIM_W-1:0]            lr_ff, lr_in, hr_ff, hr_in;
   logic [DIM_W-1:0]            rk_ff, rk_in, kk_ff, kk_in;
   read_tag_type                tag_ff, tag_in;
   logic signed [ACC_W-1:0]     sum_ff, sum_in, sb_ff, sb_in, sc_ff, sc_in;
   qty_type                     qty_ff, qty_in;
   logic [NUM_W-1:0]            nprime_ff, nprime_in;
   div_type                     dsel_ff, dsel_in;
   logic                        neg_ff, neg_in;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic signed [COEF_W-1:0]    a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic signed [VACC_W-1:0]    vacc_ff, vacc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]       rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]       rsp_user_ff, rsp_user_in;
   logic [DIM_W-1:0]            width_ff, width_in, height_ff, height_in;

   // memory
   logic signed [SAMPLE_W-1:0]  grid_mem [0:DEPTH-1];
   logic signed [SAMPLE_W-1:0]  rd_data_ff;
   logic                        mem_we;
   logic [ADDR_W-1:0]           mem_waddr;
   logic [ADDR_W-1:0]           mem_raddr;

   // shared multiplier
   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]   mul_b;
   logic signed [PROD_W-1:0]    mul_p;

   // working signals
   logic [DIM_W-1:0]            ew, eh, col_x, row_x;
   logic                        nc3, nr3;
   logic signed [ACC_W-1:0]     sample_x, num, num_abs;
   logic [3:0]                  den;
   logic [1:0]                  den_sh;
   div_type                     den_div;
   logic [NUM_W-1:0]            numer;
   logic [NUM_W-1:0]            q0, qd, rem, qfix;
   logic signed [COEF_W-1:0]    coef;
   logic signed [VACC_W-1:0]    vabs;
   logic [VACC_W-1:0]           vround;
   logic signed [VALUE_W-1:0]   vmag, vout;
   logic                        value_on, slopes_on, rsp_free;

   // unpack the request
   assign req_col    = req_tdata[7:0];
   assign req_row    = req_tdata[15:8];
   assign req_sample = req_tdata[31:16];
   assign req_x      = req_tdata[47:32];
   assign req_y      = req_tdata[63:48];
   assign req_sel    = req_tdata[65:64];
   assign req_mode   = req_tuser[0];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // sample writes land at row*MAX_COLUMNS+column, outside storage is dropped
   assign mem_we = req_accept && (req_mode == MODE_WRITE) &&
                   (int'(req_col) < MAX_COLUMNS) && (int'(req_row) < MAX_ROWS);
   assign mem_waddr = ADDR_W'(int'(req_row) * MAX_COLUMNS + int'(req_col));
   assign mem_raddr = ADDR_W'(int'(rk_ff) * MAX_COLUMNS + int'(kk_ff));

   // grid memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem[mem_waddr] <= req_sample;
      end
      rd_data_ff <= grid_mem[mem_raddr];
   end

   assign mul_p = mul_a * mul_b;

   // grid size in use and window shape
   assign ew    = (width_ff > COL_CAP) ? COL_CAP : width_ff;
   assign eh    = (height_ff > ROW_CAP) ? ROW_CAP : height_ff;
   assign col_x = DIM_W'(col_ff);
   assign row_x = DIM_W'(row_ff);
   assign nc3   = ((hc_ff - lc_ff) == DIM_W'(2));
   assign nr3   = ((hr_ff - lr_ff) == DIM_W'(2));

   // divide setup: pick sum and divisor, split 2d into odd factor and shift
   always_comb begin
      case (qty_ff)
         QTY_A: begin
            num = sum_ff;
            den = (nc3 && nr3) ? 4'd9 : ((nc3 || nr3) ? 4'd6 : 4'd4);
         end
         QTY_B: begin
            num = sb_ff;
            den = nc3 ? (nr3 ? 4'd6 : 4'd4) : (nr3 ? 4'd3 : 4'd2);
         end
         QTY_C: begin
            num = sc_ff;
            den = nr3 ? (nc3 ? 4'd6 : 4'd4) : (nc3 ? 4'd3 : 4'd2);
         end
         default: begin
            num = sum_ff;
            den = 4'd4;
         end
      endcase
      case (den)
         4'd2: begin den_sh = 2'd2; den_div = DIV_ONE;   end
         4'd3: begin den_sh = 2'd1; den_div = DIV_THREE; end
         4'd4: begin den_sh = 2'd3; den_div = DIV_ONE;   end
         4'd6: begin den_sh = 2'd2; den_div = DIV_THREE; end
         4'd9: begin den_sh = 2'd1; den_div = DIV_NINE;  end
         default: begin den_sh = 2'd3; den_div = DIV_ONE; end
      endcase
      num_abs = num[ACC_W-1] ? -num : num;
      numer   = {num_abs[ACC_W-2:0], {(FRAC_W + 1){1'b0}}} + NUM_W'(den);
   end

   // divide correction: the reciprocal estimate is at most one low
   always_comb begin
      q0 = prod_ff[RECIP_SH +: NUM_W];
      case (dsel_ff)
         DIV_THREE: qd = q0 + (q0 << 1);
         DIV_NINE:  qd = q0 + (q0 << 3);
         default:   qd = q0;
      endcase
      rem = nprime_ff - qd;
      case (dsel_ff)
         DIV_THREE: qfix = q0 + NUM_W'(rem >= NUM_W'(3));
         DIV_NINE:  qfix = q0 + NUM_W'(rem >= NUM_W'(9));
         default:   qfix = nprime_ff;
      endcase
      coef = neg_ff ? -COEF_W'(qfix) : COEF_W'(qfix);
   end

   // final rounding of the Q23 value to Q8
   always_comb begin
      vabs   = vacc_ff[VACC_W-1] ? -vacc_ff : vacc_ff;
      vround = (VACC_W'(vabs) + VAL_HALF) >> VAL_SH;
      vmag   = VALUE_W'(vround);
      vout   = vacc_ff[VACC_W-1] ? -vmag : vmag;
   end

   assign value_on  = (sel_ff != SEL_SLOPES);
   assign slopes_on = (sel_ff != SEL_VALUE);
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      sel_in       = sel_ff;
      err_in       = err_ff;
      lc_in        = lc_ff;
      hc_in        = hc_ff;
      lr_in        = lr_ff;
      hr_in        = hr_ff;
      rk_in        = rk_ff;
      kk_in        = kk_ff;
      tag_in       = '0;
      sum_in       = sum_ff;
      sb_in        = sb_ff;
      sc_in        = sc_ff;
      qty_in       = qty_ff;
      nprime_in    = nprime_ff;
      dsel_in      = dsel_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      vacc_in      = vacc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      mul_a        = MUL_A_W'(b_ff);
      mul_b        = MUL_B_W'(x_ff);
      sample_x     = ACC_W'(rd_data_ff);

      // configuration writes
      if (csr_valid) begin
         case (csr_index)
            CSR_GRID_WIDTH:  width_in  = csr_data;
            CSR_GRID_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end

      // accumulate the sample read in the previous cycle
      if (tag_ff.valid) begin
         sum_in = sum_ff + sample_x;
         sb_in  = sb_ff + (tag_ff.at_hc ? sample_x : ACC_W'(0))
                        - (tag_ff.at_lc ? sample_x : ACC_W'(0));
         sc_in  = sc_ff + (tag_ff.at_hr ? sample_x : ACC_W'(0))
                        - (tag_ff.at_lr ? sample_x : ACC_W'(0));
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_mode == MODE_QUERY)) begin
               col_in   = req_col;
               row_in   = req_row;
               x_in     = req_x;
               y_in     = req_y;
               sel_in   = req_sel;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            err_in = (ew < DIM_W'(2)) || (eh < DIM_W'(2)) ||
                     (col_x >= ew) || (row_x >= eh);
            lc_in  = (col_x == '0) ? col_x : col_x - DIM_W'(1);
            hc_in  = (col_x == ew - DIM_W'(1)) ? col_x : col_x + DIM_W'(1);
            lr_in  = (row_x == '0) ? row_x : row_x - DIM_W'(1);
            hr_in  = (row_x == eh - DIM_W'(1)) ? row_x : row_x + DIM_W'(1);
            rk_in  = lr_in;
            kk_in  = lc_in;
            sum_in = '0;
            sb_in  = '0;
            sc_in  = '0;
            qty_in = QTY_A;
            state_in = err_in ? ST_DONE : ST_READ;
         end
         ST_READ: begin
            tag_in.valid = 1'b1;
            tag_in.at_lc = (kk_ff == lc_ff);
            tag_in.at_hc = (kk_ff == hc_ff);
            tag_in.at_lr = (rk_ff == lr_ff);
            tag_in.at_hr = (rk_ff == hr_ff);
            if (kk_ff == hc_ff) begin
               kk_in = lc_ff;
               if (rk_ff == hr_ff) begin
                  state_in = ST_DRAIN;
               end else begin
                  rk_in = rk_ff + DIM_W'(1);
               end
            end else begin
               kk_in = kk_ff + DIM_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DIV_MUL;
         end
         ST_DIV_MUL: begin
            nprime_in = numer >> den_sh;
            dsel_in   = den_div;
            neg_in    = num[ACC_W-1];
            mul_a     = MUL_A_W'({1'b0, nprime_in});
            mul_b     = (den_div == DIV_NINE) ? RECIP_9 : RECIP_3;
            prod_in   = mul_p;
            state_in  = ST_DIV_FIX;
         end
         ST_DIV_FIX: begin
            case (qty_ff)
               QTY_A: begin
                  a_in     = coef;
                  qty_in   = QTY_B;
                  state_in = ST_DIV_MUL;
               end
               QTY_B: begin
                  b_in     = coef;
                  qty_in   = QTY_C;
                  state_in = ST_DIV_MUL;
               end
               default: begin
                  c_in     = coef;
                  state_in = ST_MUL_X;
               end
            endcase
         end
         ST_MUL_X: begin
            mul_a    = MUL_A_W'(b_ff);
            mul_b    = MUL_B_W'(x_ff);
            prod_in  = mul_p;
            state_in = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            vacc_in  = (VACC_W'(a_ff) <<< VAL_SH) + VACC_W'(prod_ff);
            mul_a    = MUL_A_W'(c_ff);
            mul_b    = MUL_B_W'(y_ff);
            prod_in  = mul_p;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            vacc_in  = vacc_ff + VACC_W'(prod_ff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (err_ff) begin
                  rsp_data_in = '0;
                  rsp_user_in = {1'b1, 1'b0, 1'b0};
               end else begin
                  rsp_data_in = {
                     {(RSP_DATA_W - VALUE_W - 2 * SLOPE_W){1'b0}},
                     (slopes_on ? c_ff : COEF_W'(0)),
                     (slopes_on ? b_ff : COEF_W'(0)),
                     (value_on ? vout : VALUE_W'(0))
                  };
                  rsp_user_in = {1'b0, slopes_on, value_on};
               end
               err_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // register update
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tag_ff       <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= DIM_RESET;
         height_ff    <= DIM_RESET;
      end else begin
         state_ff     <= state_in;
         tag_ff       <= tag_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
      col_ff      <= col_in;
      row_ff      <= row_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      sel_ff      <= sel_in;
      lc_ff       <= lc_in;
      hc_ff       <= hc_in;
      lr_ff       <= lr_in;
      hr_ff       <= hr_in;
      rk_ff       <= rk_in;
      kk_ff       <= kk_in;
      sum_ff      <= sum_in;
      sb_ff       <= sb_in;
      sc_ff       <= sc_in;
      qty_ff      <= qty_in;
      nprime_ff   <= nprime_in;
      dsel_ff     <= dsel_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      vacc_ff     <= vacc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

`default_nettype wire
